// ----- hdl/icls_pkg.sv -----
// shared types and constants for the indexed circular list store
// no dependencies

package icls_pkg;

   localparam int INDEX_W       = 16;
   localparam int VALUE_W       = 32;
   localparam int KIND_W        = 2;
   localparam int DEFAULT_DEPTH = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_READ   = 2'd1,
      KIND_WRITE  = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

endpackage

// ----- hdl/icls_ram.sv -----
// entry storage: one write port, one read port, registered read data
// depends on icls_pkg

module icls_ram #(
   parameter int DEPTH = icls_pkg::DEFAULT_DEPTH
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [icls_pkg::VALUE_W-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [icls_pkg::VALUE_W-1:0]     rd_data
);
   import icls_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/icls_mod.sv -----
// iterative remainder unit: index modulo entry count, one quotient bit per cycle
// depends on icls_pkg

module icls_mod #(
   parameter int DEPTH = icls_pkg::DEFAULT_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [icls_pkg::INDEX_W-1:0]     dividend,
   input  logic [$clog2(DEPTH+1)-1:0]       divisor,
   output logic                             done,
   output logic [$clog2(DEPTH)-1:0]         remainder
);
   import icls_pkg::*;

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int AW     = $clog2(DEPTH);
   localparam int STEP_W = $clog2(INDEX_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [INDEX_W-1:0] shift_ff, shift_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [CW-1:0]      div_ff, div_in;
   logic [CW:0]        trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      trial    = {rem_ff, shift_ff[INDEX_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[CW-1:0];
         end
         shift_in = {shift_ff[INDEX_W-2:0], 1'b0};
         step_in  = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(INDEX_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[AW-1:0];

endmodule

// ----- hdl/indexed_circular_list_store.sv -----
// Indexed circular list store: an ordered list of up to LIST_DEPTH signed words held in
// a synchronous RAM with entry 0 at the head. One request is worked at a time and the
// request port stalls until it is finished; a finished response waits in an output
// register, so the next request is taken while it is still pending. A read, write or
// remove first reduces the index modulo the count in a bit-serial remainder unit. A
// remove then moves each later entry forward through the single RAM port pair, by way
// of ST_SHIFT and ST_SHWR for each entry. Requests on an empty list, and appends on a
// full one, go from ST_EXEC straight to ST_DONE.
// depends on icls_pkg, icls_ram, icls_mod

module indexed_circular_list_store #(
   parameter int LIST_DEPTH = icls_pkg::DEFAULT_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [icls_pkg::KIND_W-1:0]           req_kind,
   input  logic [icls_pkg::INDEX_W-1:0]          req_index,
   input  logic signed [icls_pkg::VALUE_W-1:0]   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [icls_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [$clog2(LIST_DEPTH+1)-1:0]       rsp_count,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_error
);
   import icls_pkg::*;

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int AW = $clog2(LIST_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOD,
      ST_RDWAIT,
      ST_SHIFT,
      ST_SHWR,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [VALUE_W-1:0] rd_ff, rd_in;
   logic               err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;
   logic               rsp_error_ff, rsp_error_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [VALUE_W-1:0] ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;
   logic               mod_start;
   logic               mod_done;
   logic [AW-1:0]      mod_rem;

   icls_ram #(.DEPTH(LIST_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   icls_mod #(.DEPTH(LIST_DEPTH)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (index_ff),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      index_in     = index_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      rd_in        = rd_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_error_in = rsp_error_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff;
      ram_wdata    = value_ff;
      ram_raddr    = ptr_ff + AW'(1);
      mod_start    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = kind_type'(req_kind);
               index_in = req_index;
               value_in = req_value;
               rd_in    = '0;
               err_in   = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (kind_ff == KIND_APPEND) begin
               if (count_ff == CW'(LIST_DEPTH)) begin
                  err_in = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[AW-1:0];
                  count_in  = count_ff + CW'(1);
               end
               state_in = ST_DONE;
            end else if (count_ff == '0) begin
               err_in   = (kind_ff != KIND_READ);
               state_in = ST_DONE;
            end else begin
               mod_start = 1'b1;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               ptr_in    = mod_rem;
               ram_raddr = mod_rem;
               case (kind_ff)
                  KIND_READ: begin
                     state_in = ST_RDWAIT;
                  end
                  KIND_WRITE: begin
                     ram_we    = 1'b1;
                     ram_waddr = mod_rem;
                     state_in  = ST_DONE;
                  end
                  default: begin
                     state_in = ST_SHIFT;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            rd_in    = ram_rdata;
            state_in = ST_DONE;
         end
         ST_SHIFT: begin
            if ((CW'(ptr_ff) + CW'(1)) < count_ff) begin
               state_in = ST_SHWR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_SHWR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ptr_in    = ptr_ff + AW'(1);
            state_in  = ST_SHIFT;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_ff;
               rsp_count_in = count_ff;
               rsp_error_in = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      index_ff     <= index_in;
      value_ff     <= value_in;
      ptr_ff       <= ptr_in;
      rd_ff        <= rd_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = (rsp_count_ff == '0);
   assign rsp_error      = rsp_error_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LIST_DEPTH))
      else $error("entry count above list depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request port open right after a request was taken");

   a_mod_done_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == ST_MOD)
      else $error("remainder finished outside the index reduction step");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHWR |-> (CW'(ptr_ff) + CW'(1)) < count_ff)
      else $error("entry move beyond the list end");

endmodule
